// ----- sv/msb_first_bit_packer_unit_assert.svh -----
// Assertion macros for the bit packer checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef MSB_FIRST_BIT_PACKER_UNIT_ASSERT_SVH
`define MSB_FIRST_BIT_PACKER_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define MFBP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define MFBP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// implication checked during reset as well
`define MFBP_ASSERT_ALWAYS(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

// ----- sv/mfbp_pkg.sv -----
// Shared types and constants for the MSB-first bit packer.
// No dependencies.
`default_nettype none

package mfbp_pkg;

	localparam int ADDR_BITS_DEF = 32;
	localparam int MAX_BITS      = 32;
	localparam int QUEUE_DEPTH   = 4;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_FLUSH = 2'd1,
		KIND_SEEK  = 2'd2
	} kind_t;

	// one queued job: up to four left-aligned bytes, or a seek address
	typedef struct packed {
		logic        seek;
		logic [2:0]  nbytes;
		logic [31:0] data;
	} job_t;

endpackage

`default_nettype wire

// ----- sv/mfbp_front.sv -----
// Front end: accepts items, merges write bits with the partial byte, builds jobs.
// Depends on mfbp_pkg.
`default_nettype none

module mfbp_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [1:0]        kind,
	input  wire logic [31:0]       value,
	input  wire logic [5:0]        bit_count,
	input  wire logic              push_ready,
	output logic                   push,
	output mfbp_pkg::job_t         push_job
);

	logic [6:0]  part_q;
	logic [2:0]  fill_q;

	logic        accept;
	logic [5:0]  total;
	logic [32:0] mask;
	logic [38:0] acc;
	logic [39:0] aligned;
	logic [6:0]  part_next;
	logic [7:0]  flush_byte;
	logic        wr_ok;

	assign accept = in_valid && push_ready;

	always_comb begin
		total      = {3'b000, fill_q} + bit_count;
		mask       = ~({33{1'b1}} << bit_count);
		acc        = ({32'b0, part_q} << bit_count) | {7'b0, value & mask[31:0]};
		aligned    = {1'b0, acc} << (6'd40 - total);
		part_next  = acc[6:0] & ~(7'h7f << total[2:0]);
		flush_byte = {1'b0, part_q} << (4'd8 - {1'b0, fill_q});
		wr_ok      = (bit_count != 6'd0) && (bit_count <= 6'(mfbp_pkg::MAX_BITS));
		push       = 1'b0;
		push_job   = '{seek: 1'b0, nbytes: total[5:3], data: aligned[39:8]};
		case (mfbp_pkg::kind_t'(kind))
			mfbp_pkg::KIND_WRITE: begin
				push = accept && wr_ok && (total[5:3] != 3'd0);
			end
			mfbp_pkg::KIND_FLUSH: begin
				push     = accept && (fill_q != 3'd0);
				push_job = '{seek: 1'b0, nbytes: 3'd1, data: {flush_byte, 24'b0}};
			end
			mfbp_pkg::KIND_SEEK: begin
				push     = accept;
				push_job = '{seek: 1'b1, nbytes: 3'd0, data: value};
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q <= '0;
			fill_q <= '0;
		end else if (accept) begin
			case (mfbp_pkg::kind_t'(kind))
				mfbp_pkg::KIND_WRITE: begin
					if (wr_ok) begin
						part_q <= part_next;
						fill_q <= total[2:0];
					end
				end
				mfbp_pkg::KIND_FLUSH, mfbp_pkg::KIND_SEEK: begin
					part_q <= '0;
					fill_q <= '0;
				end
				default: begin
					part_q <= part_q;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- sv/mfbp_queue.sv -----
// Short job queue between front and back end, flip-flop storage.
// Depends on mfbp_pkg.
`default_nettype none

module mfbp_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire mfbp_pkg::job_t push_job,
	output logic                push_ready,
	input  wire logic           pop,
	output logic                pop_valid,
	output mfbp_pkg::job_t      pop_job
);

	localparam int PTR_BITS = $clog2(mfbp_pkg::QUEUE_DEPTH);
	localparam int CNT_BITS = $clog2(mfbp_pkg::QUEUE_DEPTH + 1);

	mfbp_pkg::job_t        slot_q [mfbp_pkg::QUEUE_DEPTH];
	logic [PTR_BITS-1:0]   wr_ptr_q;
	logic [PTR_BITS-1:0]   rd_ptr_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  do_push;
	logic                  do_pop;

	assign push_ready = (cnt_q != CNT_BITS'(mfbp_pkg::QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_job    = slot_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(mfbp_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(mfbp_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/mfbp_back.sv -----
// Back end: holds the byte position, emits queued bytes one byte per cycle while not stalled.
// Depends on mfbp_pkg.
`default_nettype none

module mfbp_back #(
	parameter int ADDR_BITS = mfbp_pkg::ADDR_BITS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           pop_valid,
	input  wire mfbp_pkg::job_t pop_job,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic [7:0]          out_byte,
	output logic [31:0]         byte_addr,
	output logic                last
);

	logic [ADDR_BITS-1:0] pos_q;
	logic [31:0]          data_q;
	logic [2:0]           rem_q;
	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	logic [31:0]          byte_addr_q;
	logic                 last_q;
	logic                 emit;
	logic                 free;

	assign emit = (rem_q != 3'd0) && (!out_valid_q || !out_stall);
	assign free = (rem_q == 3'd0) || ((rem_q == 3'd1) && emit);
	assign pop  = pop_valid && free;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign byte_addr = byte_addr_q;
	assign last      = last_q;

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q  <= data_q[31:24];
			byte_addr_q <= 32'(pos_q);
			last_q      <= (rem_q == 3'd1);
		end
		if (pop) begin
			data_q <= pop_job.data;
		end else if (emit) begin
			data_q <= {data_q[23:0], 8'h00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rem_q       <= '0;
			pos_q       <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				rem_q <= pop_job.seek ? 3'd0 : pop_job.nbytes;
			end else if (emit) begin
				rem_q <= rem_q - 1'b1;
			end
			if (pop && pop_job.seek) begin
				pos_q <= ADDR_BITS'(pop_job.data);
			end else if (emit) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/msb_first_bit_packer_unit.sv -----
// Top level of the MSB-first bit packer: front end, job queue, back end.
// Depends on mfbp_pkg, mfbp_front, mfbp_queue, mfbp_back.
//
//  channel | handshake          | word
//  in      | in_valid, in_stall  | kind, value, bit_count
//  out     | out_valid, out_stall| out_byte, byte_addr, last
//
// The front end takes one word per cycle while the job queue has room.
// The back end emits one byte per cycle while out_stall is low, so a write that
// completes n bytes yields n output bytes; a seek yields none.
// A first byte passes the queue, the back-end job register and the output register.
// Reset clears partial bits, fill count, byte position, queue and output valid.
`default_nettype none

module msb_first_bit_packer_unit #(
	parameter int ADDR_BITS = mfbp_pkg::ADDR_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  kind,
	input  wire logic [31:0] value,
	input  wire logic [5:0]  bit_count,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic [31:0]      byte_addr,
	output logic             last
);

	logic           push;
	logic           push_ready;
	mfbp_pkg::job_t push_job;
	logic           pop;
	logic           pop_valid;
	mfbp_pkg::job_t pop_job;

	assign in_stall = !push_ready;

	mfbp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.kind       (kind),
		.value      (value),
		.bit_count  (bit_count),
		.push_ready (push_ready),
		.push       (push),
		.push_job   (push_job)
	);

	mfbp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_job    (pop_job)
	);

	mfbp_back #(
		.ADDR_BITS (ADDR_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_job    (pop_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.byte_addr  (byte_addr),
		.last       (last)
	);

endmodule

`default_nettype wire

// ----- sv/mfbp_checker.sv -----
// Port-level checks for the bit packer, bound to the top level.
// Depends on msb_first_bit_packer_unit_assert.svh.
`default_nettype none
`include "msb_first_bit_packer_unit_assert.svh"

module mfbp_checker #(
	parameter int ADDR_BITS = 32
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [7:0]  out_byte,
	input wire logic [31:0] byte_addr,
	input wire logic        last
);

	localparam logic [31:0] ADDR_MASK = (ADDR_BITS >= 32) ? '1 :
		32'((64'd1 << ADDR_BITS) - 64'd1);

	logic out_take;

	assign out_take = out_valid && !out_stall;

	`MFBP_ASSERT_ALWAYS(a_reset_quiet, !arst_n, !out_valid, "output valid during reset")

	`MFBP_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(out_byte) && $stable(byte_addr) && $stable(last),
		"stalled output word changed")

	`MFBP_ASSERT_NEXT(a_burst_seq, out_take && !last,
		out_valid && (((byte_addr - $past(byte_addr)) & ADDR_MASK) == 32'd1),
		"byte of one item missing or out of order")

	`MFBP_ASSERT_NOW(a_addr_range, out_valid, (byte_addr & ~ADDR_MASK) == 32'd0,
		"byte position beyond address width")

endmodule

bind msb_first_bit_packer_unit mfbp_checker #(.ADDR_BITS(ADDR_BITS)) u_mfbp_checker (.*);

`default_nettype wire

// ----- bench/tb_msb_first_bit_packer_unit.sv -----
// Self-checking bench for msb_first_bit_packer_unit: directed and random words, scored per byte.
// Depends on mfbp_pkg and msb_first_bit_packer_unit; needs nothing else.
`timescale 1ns / 100ps

module tb_msb_first_bit_packer_unit;

	localparam int CLK_HALF = 4;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES = 60;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	class byte_scoreboard;
		typedef struct {
			logic [7:0]  data;
			logic [31:0] addr;
			logic        last;
		} packed_byte_t;

		packed_byte_t expected_bytes[$];
		logic [6:0]   pend_bits;
		logic [2:0]   pend_cnt;
		logic [31:0]  next_addr;
		int           errors;

		function new();
			pend_bits = '0;
			pend_cnt = '0;
			next_addr = '0;
			errors = 0;
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction

		function void emit(logic [7:0] b, logic is_last);
			packed_byte_t rec;
			rec.data = b;
			rec.addr = next_addr;
			rec.last = is_last;
			expected_bytes.push_back(rec);
			next_addr = next_addr + 32'd1;
		endfunction

		function void note_word(logic [1:0] k, logic [31:0] v, logic [5:0] n);
			logic [63:0] acc;
			logic [7:0]  b;
			int          total;
			if (k == mfbp_pkg::KIND_WRITE) begin
				if (n >= 6'd1 && n <= 6'd32) begin
					acc = ({57'd0, pend_bits} << n) | ({32'd0, v} & ((64'd1 << n) - 64'd1));
					total = int'(pend_cnt) + int'(n);
					while (total >= 8) begin
						b = 8'(acc >> (total - 8));
						total -= 8;
						emit(b, total < 8);
					end
					pend_bits = 7'(acc & ((64'd1 << total) - 64'd1));
					pend_cnt = 3'(total);
				end
			end else if (k == mfbp_pkg::KIND_FLUSH) begin
				if (pend_cnt != 3'd0) begin
					b = {1'b0, pend_bits} << (8 - int'(pend_cnt));
					emit(b, 1'b1);
				end
				pend_bits = '0;
				pend_cnt = '0;
			end else if (k == mfbp_pkg::KIND_SEEK) begin
				pend_bits = '0;
				pend_cnt = '0;
				next_addr = v;
			end
		endfunction

		function void check_byte(logic [7:0] b, logic [31:0] a, logic l);
			packed_byte_t exp_rec;
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected byte %02h addr %08h last %0b", $time, b, a, l);
				errors++;
				return;
			end
			exp_rec = expected_bytes.pop_front();
			if (b !== exp_rec.data) begin
				$display("%0t: out_byte expected %02h actual %02h", $time, exp_rec.data, b);
				errors++;
			end
			if (a !== exp_rec.addr) begin
				$display("%0t: byte_addr expected %08h actual %08h", $time, exp_rec.addr, a);
				errors++;
			end
			if (l !== exp_rec.last) begin
				$display("%0t: last expected %0b actual %0b", $time, exp_rec.last, l);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  kind;
	logic [31:0] value;
	logic [5:0]  bit_count;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_byte;
	logic [31:0] byte_addr;
	logic        last;

	byte_scoreboard sb;
	int             send_idle;
	int             recv_idle;
	int             cycles;
	logic           holding;
	event           hold_off_go;

	msb_first_bit_packer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.value(value),
		.bit_count(bit_count),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.byte_addr(byte_addr),
		.last(last)
	);

	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= holding || ($urandom_range(99) < recv_idle);
	end

	// hold the output side for a long stretch
	initial begin
		holding = 1'b0;
		forever begin
			@(hold_off_go);
			holding <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			holding <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_byte(out_byte, byte_addr, last);
	end

	task automatic send_word(logic [1:0] k, logic [31:0] v, logic [5:0] n);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		value <= v;
		bit_count <= n;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_word(k, v, n);
	endtask

	task automatic run_random_phase(int words, bit with_hold);
		logic [1:0]  k;
		logic [31:0] v;
		logic [5:0]  n;
		int          done;
		int          pick;
		done = 0;
		while (done < words) begin
			if (with_hold && done == words / 3)
				-> hold_off_go;
			pick = $urandom_range(99);
			v = $urandom();
			n = 6'($urandom_range(1, 32));
			if ($urandom_range(1))
				n = 6'($urandom_range(1, 8));
			if (pick < 66) begin
				k = mfbp_pkg::KIND_WRITE;
				done++;
			end else if (pick < 78) begin
				k = mfbp_pkg::KIND_FLUSH;
				done++;
			end else if (pick < 86) begin
				k = mfbp_pkg::KIND_SEEK;
				if ($urandom_range(1))
					v = 32'hFFFF_FFFF - 32'($urandom_range(3));
				done++;
			end else if (pick < 90) begin
				k = mfbp_pkg::KIND_WRITE;
				n = 6'd0;
			end else if (pick < 95) begin
				k = mfbp_pkg::KIND_WRITE;
				n = 6'($urandom_range(33, 63));
			end else begin
				k = KIND_UNUSED;
				n = 6'($urandom_range(63));
			end
			send_word(k, v, n);
		end
	endtask

	initial begin
		sb = new();
		send_idle = 36;
		recv_idle = 81;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		kind <= mfbp_pkg::KIND_WRITE;
		value <= '0;
		bit_count <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(mfbp_pkg::KIND_WRITE, 32'hFFFF_FFFF, 6'd32);
		send_word(mfbp_pkg::KIND_WRITE, 32'h1234_5678, 6'd0);
		send_word(mfbp_pkg::KIND_WRITE, 32'h0000_0001, 6'd1);
		send_word(mfbp_pkg::KIND_FLUSH, 32'h0, 6'd0);
		send_word(mfbp_pkg::KIND_FLUSH, 32'hFFFF_FFFF, 6'd63);
		send_word(mfbp_pkg::KIND_WRITE, 32'hFFFF_FFFF, 6'd33);
		send_word(mfbp_pkg::KIND_WRITE, 32'hFFFF_FFFF, 6'd63);
		send_word(KIND_UNUSED, 32'hFFFF_FFFF, 6'd8);
		send_word(mfbp_pkg::KIND_SEEK, 32'hFFFF_FFFE, 6'd0);
		send_word(mfbp_pkg::KIND_WRITE, 32'h0000_007F, 6'd7);
		send_word(mfbp_pkg::KIND_WRITE, 32'hA5A5_A5A5, 6'd32);
		send_word(mfbp_pkg::KIND_WRITE, 32'h0000_0005, 6'd3);
		send_word(mfbp_pkg::KIND_SEEK, 32'h0000_0000, 6'd32);
		send_word(mfbp_pkg::KIND_WRITE, 32'h0000_0000, 6'd8);
		send_word(mfbp_pkg::KIND_WRITE, 32'h0000_00FF, 6'd8);
		send_word(mfbp_pkg::KIND_WRITE, 32'h8000_0000, 6'd32);
		send_word(mfbp_pkg::KIND_WRITE, 32'h0000_0055, 6'd7);
		send_word(mfbp_pkg::KIND_FLUSH, 32'h0, 6'd0);
		send_word(mfbp_pkg::KIND_WRITE, 32'h0000_0000, 6'd31);
		send_word(mfbp_pkg::KIND_FLUSH, 32'h0, 6'd0);

		run_random_phase(30, 1'b0);
		send_idle = 81;
		recv_idle = 36;
		run_random_phase(25, 1'b0);
		send_idle = 0;
		recv_idle = 0;
		run_random_phase(25, 1'b1);
		in_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
